// ===== rtl/swrm_pkg.sv =====
// ----------------------------------------------------------------------------
// swrm_pkg: shared definitions for the stack with running max
// operation codes, status codes, default sizes and the cell control bundle
// ----------------------------------------------------------------------------
package swrm_pkg;

   localparam int DEFAULT_STACK_DEPTH = 256;
   localparam int DEFAULT_DATA_WIDTH  = 32;

   // request operation
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // response status
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

   // shift control shared by every cell of the chain
   typedef struct packed {
      logic shift_down;   // push: every cell takes its upper neighbor
      logic shift_up;     // pop: every cell takes its lower neighbor
   } cell_ctl_type;

endpackage

// ===== rtl/swrm_cell.sv =====
// ----------------------------------------------------------------------------
// swrm_cell: one stack slot
// holds a value and the largest value from this slot down to the bottom
// ----------------------------------------------------------------------------
module swrm_cell import swrm_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                         clock,
   input  cell_ctl_type                 ctl,
   input  logic signed [DATA_WIDTH-1:0] upper_value,
   input  logic signed [DATA_WIDTH-1:0] upper_max,
   input  logic signed [DATA_WIDTH-1:0] lower_value,
   input  logic signed [DATA_WIDTH-1:0] lower_max,
   output logic signed [DATA_WIDTH-1:0] value,
   output logic signed [DATA_WIDTH-1:0] run_max
);

   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic signed [DATA_WIDTH-1:0] max_ff, max_in;

   always_comb begin
      value_in = value_ff;
      max_in   = max_ff;
      if (ctl.shift_down) begin
         value_in = upper_value;
         max_in   = upper_max;
      end else if (ctl.shift_up) begin
         value_in = lower_value;
         max_in   = lower_max;
      end
   end

   // payload only, slots above the occupancy are never read
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      max_ff   <= max_in;
   end

   assign value   = value_ff;
   assign run_max = max_ff;

endmodule

// ===== rtl/stack_with_running_max_core.sv =====
// ----------------------------------------------------------------------------
// stack_with_running_max_core: lifo stack that reports its maximum
// a chain of slot cells that shifts down on push and up on pop
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -------------------------
//  request   req_action, req_value                   start high, busy low
//  response  rsp_popped_value, rsp_current_max,      rsp_valid for one cycle,
//            rsp_max_valid, rsp_status,              no back pressure
//            rsp_occupancy
//
//  one request per cycle; the response appears in the cycle after acceptance
//  the top two cells and the occupancy counter settle every response, so no
//  memory read sits in the path and busy never rises
//  reset clears the occupancy and the response strobe; cell contents are
//  left as they are since slots above the occupancy are never read
//  the receiver cannot stall, so nothing backs up inside the block
// ----------------------------------------------------------------------------
module stack_with_running_max_core import swrm_pkg::*; #(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
   parameter int DATA_WIDTH  = DEFAULT_DATA_WIDTH,
   localparam int CountWidth = $clog2(STACK_DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   // request
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   // response
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_popped_value,
   output logic signed [DATA_WIDTH-1:0] rsp_current_max,
   output logic                         rsp_max_valid,
   output logic [1:0]                   rsp_status,
   output logic [CountWidth-1:0]        rsp_occupancy
);

   // cell chain taps
   logic signed [DATA_WIDTH-1:0] cell_value [STACK_DEPTH];
   logic signed [DATA_WIDTH-1:0] cell_max   [STACK_DEPTH];

   logic [CountWidth-1:0] count_ff, count_in;
   cell_ctl_type          ctl;

   logic                         accept;
   logic                         empty;
   logic                         full;
   logic                         one_left;
   logic signed [DATA_WIDTH-1:0] push_max;

   logic                         valid_ff, valid_in;
   logic signed [DATA_WIDTH-1:0] popped_ff, popped_in;
   logic signed [DATA_WIDTH-1:0] cur_max_ff, cur_max_in;
   logic                         max_valid_ff, max_valid_in;
   logic [1:0]                   status_ff, status_in;

   // every request completes in the cycle it is taken
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CountWidth'(STACK_DEPTH));
   assign one_left = (count_ff == CountWidth'(1));

   // running max of the new top slot; equal values keep the old max
   assign push_max = (empty || (req_value > cell_max[0])) ? req_value : cell_max[0];

   always_comb begin
      ctl          = '0;
      count_in     = count_ff;
      valid_in     = accept;
      popped_in    = '0;
      cur_max_in   = empty ? '0 : cell_max[0];
      max_valid_in = !empty;
      status_in    = STATUS_OK;

      if (accept) begin
         case (req_action)
            OP_PUSH: begin
               if (full) begin
                  status_in = STATUS_PUSH_FULL;
               end else begin
                  ctl.shift_down = 1'b1;
                  count_in       = count_ff + CountWidth'(1);
                  cur_max_in     = push_max;
                  max_valid_in   = 1'b1;
               end
            end
            OP_POP: begin
               if (empty) begin
                  status_in = STATUS_POP_EMPTY;
               end else begin
                  ctl.shift_up = 1'b1;
                  count_in     = count_ff - CountWidth'(1);
                  popped_in    = cell_value[0];
                  // the slot below the top holds the max of what remains
                  cur_max_in   = one_left ? '0 : cell_max[1];
                  max_valid_in = !one_left;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   // chain of slots, slot 0 is the top of the stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] up_value, up_max, low_value, low_max;

      if (i == 0) begin : g_top
         assign up_value = req_value;
         assign up_max   = push_max;
      end else begin : g_mid
         assign up_value = cell_value[i-1];
         assign up_max   = cell_max[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign low_value = cell_value[i];
         assign low_max   = cell_max[i];
      end else begin : g_inner
         assign low_value = cell_value[i+1];
         assign low_max   = cell_max[i+1];
      end

      swrm_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .upper_value (up_value),
         .upper_max   (up_max),
         .lower_value (low_value),
         .lower_max   (low_max),
         .value       (cell_value[i]),
         .run_max     (cell_max[i])
      );
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      popped_ff    <= popped_in;
      cur_max_ff   <= cur_max_in;
      max_valid_ff <= max_valid_in;
      status_ff    <= status_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_current_max  = cur_max_ff;
   assign rsp_max_valid    = max_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = count_ff;

endmodule

// ===== tb/stack_with_running_max_core_test.sv =====
// ----------------------------------------------------------------------------
// stack_with_running_max_core_test: self-checking bench for the max stack
// pushes and pops signed values through the command port with random gaps,
// tracks the stack and its maximum records in a scoreboard class, and checks
// every response field against the tracked state in request order
// ----------------------------------------------------------------------------
module stack_with_running_max_core_test;
   import swrm_pkg::*;

   localparam int DEPTH       = DEFAULT_STACK_DEPTH;
   localparam int WIDTH       = DEFAULT_DATA_WIDTH;
   localparam int OCC_W       = $clog2(DEPTH + 1);
   localparam int ITEM_TARGET = 1350;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   // one response as the block presents it
   typedef struct packed {
      logic signed [WIDTH-1:0] popped;
      logic signed [WIDTH-1:0] current_max;
      logic                    max_valid;
      logic [1:0]              status;
      logic [OCC_W-1:0]        occupancy;
   } stack_result_type;

   // tracks stack contents and max records, queues the expected responses
   class stack_max_tracker;
      logic signed [WIDTH-1:0] slot_value [DEPTH];
      int unsigned             max_slot [DEPTH];
      int unsigned             depth_now;
      int unsigned             max_records;
      stack_result_type        expected_results [$];
      int unsigned             mismatches;

      function new();
         depth_now   = 0;
         max_records = 0;
         mismatches  = 0;
      endfunction

      // value of the newest max record, zero when nothing is stacked
      function logic signed [WIDTH-1:0] top_maximum();
         if (depth_now == 0 || max_records == 0)
            return '0;
         return slot_value[max_slot[max_records - 1]];
      endfunction

      function void note_request(logic action, logic signed [WIDTH-1:0] value);
         stack_result_type want;
         want = '0;
         if (action == OP_PUSH) begin
            if (depth_now >= DEPTH) begin
               want.status = STATUS_PUSH_FULL;
            end else begin
               // strictly greater makes a new record; ties leave the old one
               if (depth_now == 0 || value > top_maximum()) begin
                  if (max_records < DEPTH) begin
                     max_slot[max_records] = depth_now;
                     max_records++;
                  end
               end
               slot_value[depth_now] = value;
               depth_now++;
               want.status = STATUS_OK;
            end
         end else begin
            if (depth_now == 0) begin
               want.status = STATUS_POP_EMPTY;
            end else begin
               depth_now--;
               want.popped = slot_value[depth_now];
               if (max_records > 0 && max_slot[max_records - 1] >= depth_now)
                  max_records--;
               want.status = STATUS_OK;
            end
         end
         want.current_max = top_maximum();
         want.max_valid   = (depth_now != 0);
         want.occupancy   = OCC_W'(depth_now);
         expected_results = {expected_results, want};
      endfunction

      function void flag(string field, logic [WIDTH-1:0] want, logic [WIDTH-1:0] got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: expected %0h, got %0h", field, want, got);
      endfunction

      function void check_response(stack_result_type got);
         stack_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: popped %0h max %0h occupancy %0d",
                        got.popped, got.current_max, got.occupancy);
            return;
         end
         want = expected_results.pop_front();
         if (got.popped !== want.popped)
            flag("popped_value", want.popped, got.popped);
         if (got.current_max !== want.current_max)
            flag("current_max", want.current_max, got.current_max);
         if (got.max_valid !== want.max_valid)
            flag("max_valid", WIDTH'(want.max_valid), WIDTH'(got.max_valid));
         if (got.status !== want.status)
            flag("status", WIDTH'(want.status), WIDTH'(got.status));
         if (got.occupancy !== want.occupancy)
            flag("occupancy", WIDTH'(want.occupancy), WIDTH'(got.occupancy));
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_action;
   logic signed [WIDTH-1:0] req_value;
   logic                    rsp_valid;
   logic signed [WIDTH-1:0] rsp_popped_value;
   logic signed [WIDTH-1:0] rsp_current_max;
   logic                    rsp_max_valid;
   logic [1:0]              rsp_status;
   logic [OCC_W-1:0]        rsp_occupancy;

   stack_max_tracker ledger = new();

   int unsigned cycle_count = 0;
   int unsigned items_sent  = 0;
   // occupancy the stimulus is steering toward, kept on the driver side so
   // that loop conditions never race the monitor
   int unsigned planned_depth = 0;

   stack_with_running_max_core #(
      .STACK_DEPTH (DEPTH),
      .DATA_WIDTH  (WIDTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_current_max  (rsp_current_max),
      .rsp_max_valid    (rsp_max_valid),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   // 10 unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog: a hung handshake or a lost response ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // monitor: note the accepted request first so a combinational response
   // would still find its expectation; since the response is registered, the one
   // at this edge belongs to an older request at the front of the queue
   always @(posedge clock) begin : monitor
      stack_result_type seen;
      if (!reset) begin
         if (start && !busy)
            ledger.note_request(req_action, req_value);
         if (rsp_valid) begin
            seen.popped      = rsp_popped_value;
            seen.current_max = rsp_current_max;
            seen.max_valid   = rsp_max_valid;
            seen.status      = rsp_status;
            seen.occupancy   = rsp_occupancy;
            ledger.check_response(seen);
         end
      end
   end

   // one request: idle through the gap, present it, hold until accepted
   task automatic send(input logic action, input logic signed [WIDTH-1:0] value,
                       input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start      <= 1'b1;
      req_action <= action;
      req_value  <= value;
      do @(posedge clock); while (busy);
      items_sent++;
      if (action == OP_PUSH && planned_depth < DEPTH)
         planned_depth++;
      else if (action == OP_POP && planned_depth > 0)
         planned_depth--;
   endtask

   // sender holds off until every outstanding response has come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
   endtask

   function automatic int unsigned draw_gap(bit idle_on);
      return idle_on ? $urandom_range(0, 15) : 0;
   endfunction

   // mix of extremes, small values that tie often, and full random words
   function automatic logic signed [WIDTH-1:0] pick_value(bit tie_heavy);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (tie_heavy && sel < 7)
         return WIDTH'($signed($urandom_range(0, 6)) - 3);
      case (sel)
         0: return {1'b0, {(WIDTH-1){1'b1}}};
         1: return {1'b1, {(WIDTH-1){1'b0}}};
         2, 3, 4: return WIDTH'($signed($urandom_range(0, 6)) - 3);
         default: return WIDTH'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic signed [WIDTH-1:0] max_pos;
      logic signed [WIDTH-1:0] min_neg;
      int unsigned             mode;
      int unsigned             seg_len;
      int unsigned             push_pct;
      bit                      idle_on;
      logic                    act;

      max_pos = {1'b0, {(WIDTH-1){1'b1}}};
      min_neg = {1'b1, {(WIDTH-1){1'b0}}};

      reset      = 1'b1;
      start      = 1'b0;
      req_action = OP_PUSH;
      req_value  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, first push records even when negative,
      // smaller and equal pushes make no record, extremes, unwind
      send(OP_POP,  32'sd7, 0);
      send(OP_PUSH, min_neg, 0);
      send(OP_PUSH, -32'sd5, 1);
      send(OP_PUSH, -32'sd5, 0);
      send(OP_PUSH, 32'sd0, 2);
      send(OP_PUSH, 32'sd0, 0);
      send(OP_PUSH, -32'sd1, 0);
      send(OP_PUSH, max_pos, 3);
      send(OP_PUSH, max_pos, 0);
      send(OP_PUSH, 32'sd100, 0);
      send(OP_POP,  max_pos, 0);
      send(OP_POP,  32'sd0, 0);
      send(OP_POP,  32'sd0, 1);
      send(OP_POP,  -32'sd1, 0);
      send(OP_POP,  32'sd0, 0);
      send(OP_POP,  32'sd0, 0);
      send(OP_POP,  32'sd0, 5);
      send(OP_POP,  32'sd0, 0);
      send(OP_POP,  32'sd0, 0);
      send(OP_PUSH, max_pos, 0);
      send(OP_POP,  min_neg, 0);
      wait_drained();

      // fill to capacity, push into a full stack, then unwind past empty
      idle_on = 1'b0;
      while (planned_depth < DEPTH) begin
         send(OP_PUSH, pick_value($urandom_range(0, 1) == 1), draw_gap(idle_on));
         if ($urandom_range(0, 63) == 0)
            idle_on = !idle_on;
      end
      repeat (3) send(OP_PUSH, pick_value(1'b0), draw_gap(1'b1));
      while (planned_depth > 0)
         send(OP_POP, WIDTH'($urandom), draw_gap($urandom_range(0, 3) == 0));
      repeat (2) send(OP_POP, WIDTH'($urandom), 0);
      wait_drained();

      // random walk in segments that climb, descend, hover or tie a lot
      while (items_sent < ITEM_TARGET) begin
         mode    = $urandom_range(0, 3);
         seg_len = $urandom_range(20, 200);
         idle_on = $urandom_range(0, 2) != 0;
         case (mode)
            0:       push_pct = 85;
            1:       push_pct = 15;
            2:       push_pct = 50;
            default: push_pct = 55;
         endcase
         repeat (seg_len) begin
            act = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            send(act, pick_value(mode == 3), draw_gap(idle_on));
         end
         if ($urandom_range(0, 4) == 0)
            wait_drained();
      end

      // let the last responses land, then a short tail for stray strobes
      wait_drained();
      repeat (4) @(posedge clock);

      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
